// ===== rtl/core/sssd_pkg.sv =====
// Package: shared types and constants for the sphere direction sampler.
`default_nettype none
package sssd_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIVI,
      ST_DIVU,
      ST_DIVV,
      ST_WDIV,
      ST_PREP,
      ST_SQRT,
      ST_SCALE,
      ST_CORDIC,
      ST_DONE
   } state_type;

   localparam int MAX_SIDE = 64;

   function automatic logic [21:0] atan_lut(input logic [3:0] idx);
      logic [21:0] res;
      case (idx)
         4'd0:  res = 22'd2097152;
         4'd1:  res = 22'd1238021;
         4'd2:  res = 22'd654136;
         4'd3:  res = 22'd332050;
         4'd4:  res = 22'd166669;
         4'd5:  res = 22'd83416;
         4'd6:  res = 22'd41718;
         4'd7:  res = 22'd20860;
         4'd8:  res = 22'd10430;
         4'd9:  res = 22'd5215;
         4'd10: res = 22'd2608;
         4'd11: res = 22'd1304;
         4'd12: res = 22'd652;
         4'd13: res = 22'd326;
         4'd14: res = 22'd163;
         default: res = 22'd81;
      endcase
      return res;
   endfunction

   function automatic logic [15:0] sat_q15(input logic signed [31:0] val, input logic neg);
      logic signed [31:0] rr;
      rr = (val + 32'sd128) >>> 8;
      if (neg) rr = -rr;
      if (rr > 32'sd32767) rr = 32'sd32767;
      if (rr < -32'sd32768) rr = -32'sd32768;
      return rr[15:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sssd_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module sssd_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [22:0] dividend,
   input  wire logic [12:0] divisor,
   output logic             busy,
   output logic [22:0]      quotient,
   output logic [12:0]      remainder
);
   logic [22:0] quo_ff, quo_in;
   logic [12:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [12:0] div_ff, div_in;
   logic [13:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      div_in = div_ff;
      trial  = {rem_ff, quo_ff[22]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = 5'd23;
         div_in = divisor;
      end else if (cnt_ff != 5'd0) begin
         cnt_in = cnt_ff - 5'd1;
         if (trial >= {1'b0, div_ff}) begin
            rem_in = 13'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[21:0], 1'b1};
         end else begin
            rem_in = trial[12:0];
            quo_in = {quo_ff[21:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy      = (cnt_ff != 5'd0);
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

// ===== rtl/core/stratified_sphere_direction_sampler.sv =====
// Top level: stratified uniform sphere direction sampler.
// Flow: from request accept to rsp_tvalid, four divides on the shared divider
// (row/column, u, v and weight), 16 square-root steps, 16 CORDIC steps, and
// the PREP, SCALE and DONE states for setup, scaling and output.
// Throughput: one request at a time; req_tready is high only in idle with no
// response pending, so a new request waits until the last response is taken.
// Reset: synchronous, active high; side returns to 22, stratum index to 0.
`default_nettype none
module stratified_sphere_direction_sampler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [6:0]  csr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // jitter_x, jitter_y
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata    // dir_x, dir_y, dir_z, weight
);
   import sssd_pkg::*;

   localparam logic [12:0] MAX_S = 13'(MAX_SIDE);

   state_type state_ff, state_in;
   logic [6:0]  side_reg_ff;
   logic [11:0] idx_ff, idx_in;
   logic [12:0] side_ff, col_ff, row_ff, cnt2_ff;
   logic [15:0] jx_ff, jy_ff, u_ff, v_ff, z_ff, w_ff;
   logic [31:0] n_ff, root_ff, bit_ff;
   logic signed [31:0] x_ff, y_ff;
   logic signed [24:0] ang_ff;
   logic        neg_ff;
   logic [3:0]  step_ff;
   logic [63:0] out_ff;
   logic        ovalid_ff;
   logic        dstart;
   logic [22:0] ddividend, dquo;
   logic [12:0] ddivisor, drem;
   logic        dbusy, dstarted_ff;
   logic [12:0] side_eff;

   always_comb begin
      if (side_reg_ff == 7'd0) side_eff = 13'd1;
      else if ({6'd0, side_reg_ff} > MAX_S) side_eff = MAX_S;
      else side_eff = {6'd0, side_reg_ff};
   end

   sssd_divider u_div (
      .clock, .reset, .start(dstart), .dividend(ddividend), .divisor(ddivisor),
      .busy(dbusy), .quotient(dquo), .remainder(drem)
   );

   assign req_tready = (state_ff == ST_IDLE) && !ovalid_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = out_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid && req_tready) state_in = ST_DIVI;
         ST_DIVI:   if (dstarted_ff && !dbusy) state_in = ST_DIVU;
         ST_DIVU:   if (dstarted_ff && !dbusy) state_in = ST_DIVV;
         ST_DIVV:   if (dstarted_ff && !dbusy) state_in = ST_WDIV;
         ST_WDIV:   if (dstarted_ff && !dbusy) state_in = ST_PREP;
         ST_PREP:   state_in = ST_SQRT;
         ST_SQRT:   if (bit_ff == 32'd1) state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_CORDIC;
         ST_CORDIC: if (step_ff == 4'd15) state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      dstart    = 1'b0;
      ddividend = '0;
      ddivisor  = side_ff;
      unique case (state_ff)
         ST_DIVI: begin
            dstart    = !dstarted_ff;
            ddividend = {11'd0, idx_ff};
         end
         ST_DIVU: begin
            dstart    = !dstarted_ff;
            ddividend = {col_ff[6:0], jx_ff};
         end
         ST_DIVV: begin
            dstart    = !dstarted_ff;
            ddividend = {row_ff[6:0], jy_ff};
         end
         ST_WDIV: begin
            dstart    = !dstarted_ff;
            ddividend = 23'd65536;
            ddivisor  = cnt2_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      idx_in = idx_ff + 12'd1;
      if ({1'b0, idx_in} >= cnt2_ff) idx_in = '0;
   end

   logic [31:0] sq_trial;
   logic [31:0] dx, dy;
   assign sq_trial = root_ff + bit_ff;
   assign dx = 32'(y_ff >>> step_ff);
   assign dy = 32'(x_ff >>> step_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         side_reg_ff <= 7'd22;
         idx_ff      <= '0;
         ovalid_ff   <= 1'b0;
         dstarted_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) side_reg_ff <= csr_data;
         if (rsp_tvalid && rsp_tready) ovalid_ff <= 1'b0;
         if (state_ff != state_in) dstarted_ff <= 1'b0;
         else if (dstart) dstarted_ff <= 1'b1;
         if (state_ff == ST_DONE) begin
            ovalid_ff <= 1'b1;
            idx_ff    <= idx_in;
         end
         if (state_ff == ST_IDLE && req_tvalid && req_tready) begin
            if ({1'b0, idx_ff} >= 13'(side_eff * side_eff)) idx_ff <= '0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            jx_ff   <= req_tdata[15:0];
            jy_ff   <= req_tdata[31:16];
            side_ff <= side_eff;
            cnt2_ff <= 13'(side_eff * side_eff);
            step_ff <= '0;
         end
         ST_DIVI: begin
            if (dstarted_ff && !dbusy) begin
               row_ff <= dquo[12:0];
               col_ff <= drem;
            end
         end
         ST_DIVU: if (dstarted_ff && !dbusy) u_ff <= dquo[15:0];
         ST_DIVV: if (dstarted_ff && !dbusy) v_ff <= dquo[15:0];
         ST_WDIV: if (dstarted_ff && !dbusy) w_ff <= (dquo > 23'd65535) ? 16'hFFFF : dquo[15:0];
         ST_PREP: begin
            n_ff    <= {16'd0, v_ff} * (32'd65536 - {16'd0, v_ff});
            z_ff    <= (v_ff == 16'd0) ? 16'd32767 : 16'(17'd32768 - {1'b0, v_ff});
            root_ff <= '0;
            bit_ff  <= 32'h4000_0000;
            if (u_ff[15:14] == 2'b01 || u_ff[15:14] == 2'b10) begin
               ang_ff <= $signed({1'b0, u_ff, 8'd0}) - 25'sd8388608;
               neg_ff <= 1'b1;
            end else begin
               ang_ff <= u_ff[15] ? $signed({1'b1, u_ff, 8'd0})
                                  : $signed({1'b0, u_ff, 8'd0});
               neg_ff <= 1'b0;
            end
         end
         ST_SQRT: begin
            if (n_ff >= sq_trial) begin
               n_ff    <= n_ff - sq_trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         ST_SCALE: begin
            x_ff <= $signed(32'(({31'd0, root_ff[16:0]} * 48'd39797 + 48'd128) >> 8));
            y_ff <= '0;
         end
         ST_CORDIC: begin
            if (!ang_ff[24]) begin
               x_ff   <= x_ff - $signed(dx);
               y_ff   <= y_ff + $signed(dy);
               ang_ff <= ang_ff - $signed({3'b0, atan_lut(step_ff)});
            end else begin
               x_ff   <= x_ff + $signed(dx);
               y_ff   <= y_ff - $signed(dy);
               ang_ff <= ang_ff + $signed({3'b0, atan_lut(step_ff)});
            end
            step_ff <= step_ff + 4'd1;
         end
         ST_DONE: out_ff <= {w_ff, z_ff, sat_q15(y_ff, neg_ff), sat_q15(x_ff, neg_ff)};
         default: ;
      endcase
   end
endmodule
`default_nettype wire
